[rtl/spgc_pkg.sv]
package spgc_pkg;

    typedef logic [30:0] t_q30;

    localparam t_q30 ONE    = 31'h4000_0000;
    localparam t_q30 POLY_A = 31'd1686629713;
    localparam t_q30 POLY_B = 31'd688904866;
    localparam t_q30 POLY_C = 31'd76016977;
    localparam t_q30 K_LFE  = 31'd322122547;
    localparam t_q30 K_REAR = 31'd751619277;

    localparam int NUM_GAINS = 10;

    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_YAW    = 1'b1;

    typedef enum logic [2:0] {
        FMT_STEREO        = 3'd0,
        FMT_QUAD          = 3'd1,
        FMT_FIVE_ONE      = 3'd2,
        FMT_SEVEN_ONE     = 3'd3,
        FMT_SEVEN_ONE_TWO = 3'd4,
        FMT_BINAURAL      = 3'd5
    } t_format;

    typedef struct packed {
        logic [NUM_GAINS-1:0][15:0] gain;
        logic [3:0]                 count;
    } t_result;

    function automatic t_q30 mul30(t_q30 a, t_q30 b);
        logic [61:0] p;
        p = a * b;
        return p[60:30];
    endfunction

    function automatic logic [3:0] channel_count(t_format f);
        logic [3:0] c;
        unique case (f)
            FMT_STEREO:        c = 4'd2;
            FMT_QUAD:          c = 4'd4;
            FMT_FIVE_ONE:      c = 4'd6;
            FMT_SEVEN_ONE:     c = 4'd8;
            FMT_SEVEN_ONE_TWO: c = 4'd10;
            FMT_BINAURAL:      c = 4'd2;
            default:           c = 4'd2;
        endcase
        return c;
    endfunction

endpackage

[rtl/spgc_sine.sv]
module spgc_sine #(
    parameter int ANGLE_BITS = 16,
    parameter int TAG_W      = 1
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic [TAG_W-1:0]      i_tag,
    output logic signed [31:0]    o_sin,
    output logic [TAG_W-1:0]      o_tag
);
    import spgc_pkg::*;

    localparam int SHIFT = 32 - ANGLE_BITS;

    t_q30             z_in;
    t_q30             r_z [4];
    t_q30             r_z2 [2];
    t_q30             r_t;
    t_q30             r_t2;
    t_q30             r_m;
    logic             r_neg [5];
    logic [TAG_W-1:0] r_tag [5];

    always_comb begin
        z_in = {1'b0, i_angle[ANGLE_BITS-3:0], {SHIFT{1'b0}}};
        if (i_angle[ANGLE_BITS-2]) begin
            z_in = ONE - z_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]   <= z_in;
            r_neg[0] <= i_angle[ANGLE_BITS-1];
            r_tag[0] <= i_tag;

            r_z2[0]  <= mul30(r_z[0], r_z[0]);
            r_z[1]   <= r_z[0];

            r_t      <= POLY_B - mul30(r_z2[0], POLY_C);
            r_z2[1]  <= r_z2[0];
            r_z[2]   <= r_z[1];

            r_t2     <= POLY_A - mul30(r_z2[1], r_t);
            r_z[3]   <= r_z[2];

            r_m      <= mul30(r_z[3], r_t2);

            for (int k = 1; k < 5; k++) begin
                r_neg[k] <= r_neg[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_sin   = r_neg[4] ? -$signed({1'b0, r_m}) : $signed({1'b0, r_m});
    assign o_tag   = r_tag[4];

endmodule

[rtl/spgc_isqrt.sv]
module spgc_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [30:0]      i_rad,
    input  logic [TAG_W-1:0] i_tag,
    output logic [30:0]      o_root,
    output logic [TAG_W-1:0] o_tag
);
    import spgc_pkg::*;

    logic [62:0]      r_rem  [31];
    t_q30             r_root [31];
    logic [TAG_W-1:0] r_tag  [31];

    for (genvar k = 0; k < 31; k++) begin : g_step
        localparam int B = 30 - k;
        logic [62:0]      rem_in;
        logic [62:0]      trial;
        t_q30             root_in;
        logic [TAG_W-1:0] tag_in;

        if (k == 0) begin : g_first
            assign rem_in  = {2'b00, i_rad, 30'b0};
            assign root_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign tag_in  = r_tag[k-1];
        end

        assign trial = ({32'b0, root_in} << (B + 1)) + (63'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= tag_in;
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (31'd1 << B);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[30];
    assign o_tag  = r_tag[30];

endmodule

[rtl/spgc_recip.sv]
module spgc_recip (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_dist,
    output logic [30:0] o_att
);
    import spgc_pkg::*;

    logic [31:0] r_dsq0;
    logic        r_near0;
    logic [32:0] r_rem  [31];
    t_q30        r_q    [31];
    logic [31:0] r_dsq  [31];
    logic        r_near [31];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsq0  <= i_dist * i_dist;
            r_near0 <= (i_dist < 16'd256);
        end
    end

    for (genvar k = 0; k < 31; k++) begin : g_step
        localparam int B = 30 - k;
        logic [32:0] rem_in;
        logic [32:0] rem_sh;
        t_q30        q_in;
        logic [31:0] dsq_in;
        logic        near_in;

        if (k == 0) begin : g_first
            assign rem_in  = 33'd32768;
            assign q_in    = '0;
            assign dsq_in  = r_dsq0;
            assign near_in = r_near0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign dsq_in  = r_dsq[k-1];
            assign near_in = r_near[k-1];
        end

        assign rem_sh = {rem_in[31:0], 1'b0};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dsq[k]  <= dsq_in;
                r_near[k] <= near_in;
                if (rem_sh >= {1'b0, dsq_in}) begin
                    r_rem[k] <= rem_sh - {1'b0, dsq_in};
                    r_q[k]   <= q_in | (31'd1 << B);
                end else begin
                    r_rem[k] <= rem_sh;
                    r_q[k]   <= q_in;
                end
            end
        end
    end

    assign o_att = r_near[30] ? ONE : r_q[30];

endmodule

[rtl/spgc_obuf.sv]
module spgc_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  spgc_pkg::t_result  i_data,
    input  logic               i_ready,
    output logic               o_en,
    output logic               o_valid,
    output spgc_pkg::t_result  o_data
);
    import spgc_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_ready) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || i_ready) begin
            if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_en    = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

[rtl/surround_pan_gain_calculator.sv]
// channel   direction  handshake          payload
// request   in         i_valid / o_ready  i_azimuth, i_elevation, i_distance
// result    out        o_valid / i_ready  o_gain_* (ten), o_channel_count
// config    in         apb psel/penable   paddr, pwdata, prdata
//
// one request per cycle while o_ready is high; a request passes the angle wrap
// stage, the 5-stage sine pipeline, the 31-stage square root pipelines and the
// reciprocal pipeline, then three gain product stages, into the output register
// i_rst_n is synchronous; it empties the pipeline and restores the registers
// a waiting result lets the pipeline step once into a second output entry,
// then o_ready stays low until that entry moves out
module surround_pan_gain_calculator #(
    parameter int GAIN_FRAC_BITS = 15,
    parameter int ANGLE_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_azimuth,
    input  logic [15:0] i_elevation,
    input  logic [15:0] i_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_gain_left,
    output logic [15:0] o_gain_right,
    output logic [15:0] o_gain_center,
    output logic [15:0] o_gain_lfe,
    output logic [15:0] o_gain_left_surround,
    output logic [15:0] o_gain_right_surround,
    output logic [15:0] o_gain_left_rear,
    output logic [15:0] o_gain_right_rear,
    output logic [15:0] o_gain_left_top,
    output logic [15:0] o_gain_right_top,
    output logic [3:0]  o_channel_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spgc_pkg::*;

    localparam int DEPTH = 41;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    t_format r_format;
    logic [15:0] r_yaw;

    logic en;
    logic r_vld [DEPTH];

    logic [31:0]           az_diff;
    logic [31:0]           el_ext;
    logic [ANGLE_BITS-1:0] r_az;
    logic [ANGLE_BITS-1:0] r_el;
    logic                  r_elpos;
    logic [15:0]           r_d;

    logic signed [31:0] s_az, c_az, c_el, s_el;
    logic [16:0]        tag_az;

    logic signed [31:0] r_pan;
    t_q30               r_front, r_ht;
    logic signed [32:0] dl, dr, fsum;
    t_q30               pan_mag, u_l, u_r, apan;
    logic [92:0]        sq_tag;
    t_q30               sl, sr, att;

    t_q30 r1_att, r1_sl, r1_sr, r1_oma, r1_ab, r1_af, r1_aht, r1_g3;
    t_q30 r2_g [NUM_GAINS];
    t_q30 r2_abr, r2_sl, r2_sr;
    t_q30 r3_g [NUM_GAINS];

    t_result res;
    t_result out_data;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_STEREO;
            r_yaw    <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_FORMAT: r_format <= t_format'(pwdata[2:0]);
                REG_YAW:    r_yaw    <= pwdata[15:0];
                default:    r_yaw    <= r_yaw;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FORMAT) ? {29'b0, r_format} : {16'b0, r_yaw};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_ready = en;

    // stage 0: angle wrap
    assign az_diff = {{16{i_azimuth[15]}}, i_azimuth} - {{16{r_yaw[15]}}, r_yaw};
    assign el_ext  = {{16{i_elevation[15]}}, i_elevation};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_az    <= az_diff[ANGLE_BITS-1:0];
            r_el    <= el_ext[ANGLE_BITS-1:0];
            r_elpos <= !i_elevation[15] && (i_elevation != 16'd0);
            r_d     <= i_distance;
        end
    end

    // stages 1..5: sines
    spgc_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(17)) u_sin_az (
        .i_clk(i_clk), .i_en(en), .i_angle(r_az), .i_tag({r_elpos, r_d}),
        .o_sin(s_az), .o_tag(tag_az)
    );
    spgc_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(1)) u_cos_az (
        .i_clk(i_clk), .i_en(en), .i_angle(r_az + QUARTER), .i_tag(1'b0),
        .o_sin(c_az), .o_tag()
    );
    spgc_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(1)) u_cos_el (
        .i_clk(i_clk), .i_en(en), .i_angle(r_el + QUARTER), .i_tag(1'b0),
        .o_sin(c_el), .o_tag()
    );
    spgc_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(1)) u_sin_el (
        .i_clk(i_clk), .i_en(en), .i_angle(r_el), .i_tag(1'b0),
        .o_sin(s_el), .o_tag()
    );

    // stage 6: pan, front balance, height
    assign pan_mag = mul30(s_az[31] ? 31'(-s_az) : s_az[30:0],
                           c_el[31] ? 31'(-c_el) : c_el[30:0]);
    assign fsum    = 33'(c_az) + 33'sh0_4000_0000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pan   <= (s_az[31] ^ c_el[31]) ? -$signed({1'b0, pan_mag})
                                             : $signed({1'b0, pan_mag});
            r_front <= fsum[31:1];
            r_ht    <= (tag_az[16] && !s_el[31] && (s_el != 32'sd0)) ? s_el[30:0] : '0;
        end
    end

    assign dl   = 33'sh0_4000_0000 - 33'(r_pan);
    assign dr   = 33'sh0_4000_0000 + 33'(r_pan);
    assign u_l  = dl[31:1];
    assign u_r  = dr[31:1];
    assign apan = r_pan[31] ? 31'(-r_pan) : r_pan[30:0];

    // stages 7..37: square roots and attenuation
    spgc_isqrt #(.TAG_W(93)) u_sqrt_l (
        .i_clk(i_clk), .i_en(en), .i_rad(u_l), .i_tag({apan, r_front, r_ht}),
        .o_root(sl), .o_tag(sq_tag)
    );
    spgc_isqrt #(.TAG_W(1)) u_sqrt_r (
        .i_clk(i_clk), .i_en(en), .i_rad(u_r), .i_tag(1'b0),
        .o_root(sr), .o_tag()
    );
    spgc_recip u_recip (
        .i_clk(i_clk), .i_en(en), .i_dist(tag_az[15:0]), .o_att(att)
    );

    // stages 38..40: gain products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_att <= att;
            r1_sl  <= sl;
            r1_sr  <= sr;
            r1_oma <= ONE - sq_tag[92:62];
            r1_ab  <= mul30(att, ONE - sq_tag[61:31]);
            r1_af  <= mul30(att, sq_tag[61:31]);
            r1_aht <= mul30(att, sq_tag[30:0]);
            r1_g3  <= mul30(att, K_LFE);

            r2_g[0] <= mul30(r1_att, r1_sl);
            r2_g[1] <= mul30(r1_att, r1_sr);
            r2_g[2] <= mul30(r1_af, r1_oma);
            r2_g[3] <= r1_g3;
            r2_g[4] <= mul30(r1_ab, r1_sl);
            r2_g[5] <= mul30(r1_ab, r1_sr);
            r2_g[6] <= '0;
            r2_g[7] <= '0;
            r2_g[8] <= mul30(r1_aht, r1_sl);
            r2_g[9] <= mul30(r1_aht, r1_sr);
            r2_abr  <= mul30(r1_ab, K_REAR);
            r2_sl   <= r1_sl;
            r2_sr   <= r1_sr;

            for (int k = 0; k < NUM_GAINS; k++) begin
                r3_g[k] <= r2_g[k];
            end
            r3_g[6] <= mul30(r2_abr, r2_sl);
            r3_g[7] <= mul30(r2_abr, r2_sr);
        end
    end

    // rounding and format selection
    always_comb begin
        logic [47:0] s;
        logic [47:0] sh;
        logic        surr;
        logic        rear;
        logic        top;
        surr = (r_format == FMT_FIVE_ONE) || (r_format == FMT_SEVEN_ONE)
            || (r_format == FMT_SEVEN_ONE_TWO);
        rear = (r_format == FMT_SEVEN_ONE) || (r_format == FMT_SEVEN_ONE_TWO);
        top  = (r_format == FMT_SEVEN_ONE_TWO);
        res.count = channel_count(r_format);
        for (int k = 0; k < NUM_GAINS; k++) begin
            s  = {17'b0, r3_g[k]} + (48'd1 << (29 - GAIN_FRAC_BITS));
            sh = s >> (30 - GAIN_FRAC_BITS);
            res.gain[k] = sh[15:0];
        end
        for (int k = 2; k < 6; k++) begin
            if (!surr) begin
                res.gain[k] = '0;
            end
        end
        if (!rear) begin
            res.gain[6] = '0;
            res.gain[7] = '0;
        end
        if (!top) begin
            res.gain[8] = '0;
            res.gain[9] = '0;
        end
    end

    spgc_obuf u_obuf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vld[DEPTH-1]), .i_data(res),
        .i_ready(i_ready), .o_en(en), .o_valid(o_valid), .o_data(out_data)
    );

    assign o_gain_left           = out_data.gain[0];
    assign o_gain_right          = out_data.gain[1];
    assign o_gain_center         = out_data.gain[2];
    assign o_gain_lfe            = out_data.gain[3];
    assign o_gain_left_surround  = out_data.gain[4];
    assign o_gain_right_surround = out_data.gain[5];
    assign o_gain_left_rear      = out_data.gain[6];
    assign o_gain_right_rear     = out_data.gain[7];
    assign o_gain_left_top       = out_data.gain[8];
    assign o_gain_right_top      = out_data.gain[9];
    assign o_channel_count       = out_data.count;

endmodule

[rtl/spgc_checker.sv]
module spgc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [15:0] i_azimuth,
    input logic [15:0] i_elevation,
    input logic [15:0] i_distance,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_gain_left,
    input logic [15:0] o_gain_right,
    input logic [15:0] o_gain_center,
    input logic [15:0] o_gain_lfe,
    input logic [15:0] o_gain_left_surround,
    input logic [15:0] o_gain_right_surround,
    input logic [15:0] o_gain_left_rear,
    input logic [15:0] o_gain_right_rear,
    input logic [15:0] o_gain_left_top,
    input logic [15:0] o_gain_right_top,
    input logic [3:0]  o_channel_count,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_gain_left) && $stable(o_channel_count))
        else $error("stalled result changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_channel_count == 4'd2 || o_channel_count == 4'd4
                 || o_channel_count == 4'd6 || o_channel_count == 4'd8
                 || o_channel_count == 4'd10)
        else $error("bad channel count");

    a_front_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_channel_count < 4'd6 |-> o_gain_center == 16'd0
            && o_gain_lfe == 16'd0 && o_gain_left_surround == 16'd0
            && o_gain_right_surround == 16'd0 && o_gain_left_rear == 16'd0
            && o_gain_right_rear == 16'd0)
        else $error("surround gain set in front-only format");

    a_no_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_channel_count != 4'd10 |->
            o_gain_left_top == 16'd0 && o_gain_right_top == 16'd0)
        else $error("height gain set without height channels");

endmodule

bind surround_pan_gain_calculator spgc_checker u_checker (.*);

[tb/tb_surround_pan_gain_calculator.sv]
`timescale 1ns / 1ps

module tb_surround_pan_gain_calculator;
    import spgc_pkg::*;

    typedef longint unsigned u64;

    typedef struct {
        logic [2:0]  fmt;
        logic [15:0] yaw;
        logic [15:0] az;
        logic [15:0] el;
        logic [15:0] dist_q88;
        bit          typed;
        logic [15:0] lit_left;
        logic [15:0] lit_right;
        logic [3:0]  lit_count;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_azimuth = '0;
    logic [15:0] i_elevation = '0;
    logic [15:0] i_distance = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_gain_left, o_gain_right, o_gain_center, o_gain_lfe;
    logic [15:0] o_gain_left_surround, o_gain_right_surround;
    logic [15:0] o_gain_left_rear, o_gain_right_rear;
    logic [15:0] o_gain_left_top, o_gain_right_top;
    logic [3:0]  o_channel_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [2:0]  cur_fmt = 3'd0;
    logic [15:0] cur_yaw = 16'd0;

    t_result     gains_due[$];
    bit          typed_due[$];
    t_result     typed_gains[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          requests_taken = 0;
    longint      cycle_count = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    bit          fmt_used[8];

    surround_pan_gain_calculator u_top (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("tb_surround_pan_gain_calculator failed");
            $finish;
        end
    end

    function automatic u64 mul_q30(u64 a, u64 b);
        return (a * b) >> 30;
    endfunction

    function automatic longint sine_q30(logic [15:0] p);
        u64 z, z2, t;
        z = u64'(p[13:0]) << 16;
        if (p[14]) z = (u64'(1) << 30) - z;
        z2 = mul_q30(z, z);
        t = u64'(POLY_B) - mul_q30(z2, u64'(POLY_C));
        t = u64'(POLY_A) - mul_q30(z2, t);
        t = mul_q30(z, t);
        return p[15] ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint smul_q30(longint a, longint b);
        u64 m;
        m = mul_q30(u64'(a < 0 ? -a : a), u64'(b < 0 ? -b : b));
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic u64 root_floor(u64 x);
        u64 res, bitv;
        res = 0;
        bitv = u64'(1) << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] round_gain(u64 x);
        u64 g;
        g = (x + (u64'(1) << 14)) >> 15;
        return g[15:0];
    endfunction

    function automatic t_result pan_gains(logic [2:0] fmt, logic [15:0] yaw,
                                          logic [15:0] az_in, logic [15:0] el,
                                          logic [15:0] dist_in);
        t_result r;
        u64 g[10];
        u64 d, att, sl, sr, apan, front, back, ab, abr, ht;
        logic [15:0] az;
        longint pan, s;
        az = az_in - yaw;
        d = dist_in < 16'd26 ? 26 : u64'(dist_in);
        att = (u64'(1) << 46) / (d * d);
        if (att > (u64'(1) << 30)) att = u64'(1) << 30;
        pan = smul_q30(sine_q30(az), sine_q30(el + 16'h4000));
        sl = root_floor(u64'(((longint'(1) << 30) - pan) >>> 1) << 30);
        sr = root_floor(u64'(((longint'(1) << 30) + pan) >>> 1) << 30);
        apan = u64'(pan < 0 ? -pan : pan);
        foreach (g[i]) g[i] = 0;
        g[0] = mul_q30(att, sl);
        g[1] = mul_q30(att, sr);
        if (fmt == FMT_FIVE_ONE || fmt == FMT_SEVEN_ONE || fmt == FMT_SEVEN_ONE_TWO) begin
            front = u64'(sine_q30(az + 16'h4000) + (longint'(1) << 30)) >> 1;
            back = (u64'(1) << 30) - front;
            ab = mul_q30(att, back);
            g[2] = mul_q30(mul_q30(att, front), (u64'(1) << 30) - apan);
            g[3] = mul_q30(att, u64'(K_LFE));
            g[4] = mul_q30(ab, sl);
            g[5] = mul_q30(ab, sr);
            if (fmt != FMT_FIVE_ONE) begin
                abr = mul_q30(ab, u64'(K_REAR));
                g[6] = mul_q30(abr, sl);
                g[7] = mul_q30(abr, sr);
            end
            if (fmt == FMT_SEVEN_ONE_TWO) begin
                ht = 0;
                if ($signed(el) > 0) begin
                    s = sine_q30(el);
                    ht = s > 0 ? u64'(s) : 0;
                end
                g[8] = mul_q30(mul_q30(att, ht), sl);
                g[9] = mul_q30(mul_q30(att, ht), sr);
            end
        end
        for (int i = 0; i < NUM_GAINS; i++) r.gain[i] = round_gain(g[i]);
        case (fmt)
            FMT_QUAD:          r.count = 4'd4;
            FMT_FIVE_ONE:      r.count = 4'd6;
            FMT_SEVEN_ONE:     r.count = 4'd8;
            FMT_SEVEN_ONE_TWO: r.count = 4'd10;
            default:           r.count = 4'd2;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, field,
                 got, want);
        mismatches++;
    endtask

    // request capture and result check
    always @(posedge i_clk) begin
        t_result want, got;
        string names[NUM_GAINS];
        if (i_rst_n && i_valid && o_ready) begin
            requests_taken++;
            fmt_used[cur_fmt] = 1'b1;
            if (typed_due.size() != 0 && typed_due[0]) begin
                gains_due.push_back(typed_gains.pop_front());
            end else begin
                gains_due.push_back(pan_gains(cur_fmt, cur_yaw, i_azimuth, i_elevation,
                                              i_distance));
            end
            if (typed_due.size() != 0) void'(typed_due.pop_front());
        end
        if (i_rst_n && o_valid && i_ready) begin
            names = '{"gain_left", "gain_right", "gain_center", "gain_lfe",
                      "gain_left_surround", "gain_right_surround", "gain_left_rear",
                      "gain_right_rear", "gain_left_top", "gain_right_top"};
            got.gain = {o_gain_right_top, o_gain_left_top, o_gain_right_rear,
                        o_gain_left_rear, o_gain_right_surround, o_gain_left_surround,
                        o_gain_lfe, o_gain_center, o_gain_right, o_gain_left};
            got.count = o_channel_count;
            if (gains_due.size() == 0) begin
                report_mismatch("unexpected result", got.gain[0], 16'd0);
            end else begin
                want = gains_due.pop_front();
                for (int i = 0; i < NUM_GAINS; i++)
                    if (got.gain[i] !== want.gain[i])
                        report_mismatch(names[i], got.gain[i], want.gain[i]);
                if (got.count !== want.count)
                    report_mismatch("channel_count", 16'(got.count), 16'(want.count));
            end
            results_seen++;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side backpressure
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_done != holds_asked) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                holds_done++;
            end else if ($urandom_range(0, 99) < 70) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(logic idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (gains_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [2:0] fmt, logic [15:0] yaw);
        wait_drained();
        reg_write(REG_FORMAT, {29'd0, fmt});
        reg_write(REG_YAW, {16'd0, yaw});
        cur_fmt = fmt;
        cur_yaw = yaw;
    endtask

    task automatic send_request(logic [15:0] az, logic [15:0] el, logic [15:0] dist_q88,
                                int gap);
        i_valid <= 1'b1;
        i_azimuth <= az;
        i_elevation <= el;
        i_distance <= dist_q88;
        do @(posedge i_clk); while (!o_ready);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_elev();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (r == 7) return 16'($urandom);
        return r == 8 ? 16'h4000 : 16'hc000;
    endfunction

    function automatic logic [15:0] rand_dist();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'($urandom_range(0, 40));
        if (r < 7) return 16'($urandom_range(64, 2048));
        return 16'($urandom);
    endfunction

    t_row rows[] = '{
        '{3'd0, 16'h0000, 16'h0000, 16'h0000, 16'd256, 1, 16'd23170, 16'd23170, 4'd2},
        '{3'd0, 16'h0000, 16'h4000, 16'h0000, 16'd256, 1, 16'd0, 16'd32768, 4'd2},
        '{3'd0, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1, 16'd0, 16'd0, 4'd2},
        '{3'd0, 16'h0000, 16'h8000, 16'h4000, 16'd0, 0, 0, 0, 0},
        '{3'd0, 16'h0000, 16'h7fff, 16'hc000, 16'd25, 0, 0, 0, 0},
        '{3'd1, 16'h8000, 16'h7fff, 16'h0000, 16'd26, 0, 0, 0, 0},
        '{3'd1, 16'h8000, 16'h8000, 16'h2000, 16'd300, 0, 0, 0, 0},
        '{3'd2, 16'h7fff, 16'h8000, 16'h0000, 16'd256, 0, 0, 0, 0},
        '{3'd2, 16'h7fff, 16'hc000, 16'h1000, 16'd27, 0, 0, 0, 0},
        '{3'd3, 16'h1234, 16'h4000, 16'h3fff, 16'd512, 0, 0, 0, 0},
        '{3'd3, 16'h1234, 16'h0001, 16'hffff, 16'd1, 0, 0, 0, 0},
        '{3'd4, 16'h0000, 16'h0000, 16'h4000, 16'd256, 0, 0, 0, 0},
        '{3'd4, 16'h0000, 16'h2000, 16'h7fff, 16'd400, 0, 0, 0, 0},
        '{3'd4, 16'h0000, 16'he000, 16'h8000, 16'd200, 0, 0, 0, 0},
        '{3'd4, 16'h0000, 16'h6000, 16'h5000, 16'hffff, 0, 0, 0, 0},
        '{3'd4, 16'hc000, 16'h3000, 16'hc001, 16'd26, 0, 0, 0, 0},
        '{3'd5, 16'h4000, 16'h1111, 16'h1111, 16'd700, 0, 0, 0, 0},
        '{3'd6, 16'h0000, 16'h4000, 16'h0800, 16'd256, 0, 0, 0, 0},
        '{3'd7, 16'hffff, 16'hbfff, 16'hf000, 16'd128, 0, 0, 0, 0}
    };

    initial begin
        t_result lit;
        logic [2:0] fmt;
        logic [15:0] yaw;
        int codes;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (k > 0 && (rows[k].fmt != cur_fmt || rows[k].yaw != cur_yaw))
                set_config(rows[k].fmt, rows[k].yaw);
            typed_due.push_back(rows[k].typed);
            if (rows[k].typed) begin
                lit = '0;
                lit.gain[0] = rows[k].lit_left;
                lit.gain[1] = rows[k].lit_right;
                lit.count = rows[k].lit_count;
                typed_gains.push_back(lit);
            end
            send_request(rows[k].az, rows[k].el, rows[k].dist_q88, gap_len());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin fmt = 3'd4; yaw = 16'h8000; end
                1: begin fmt = 3'd0; yaw = 16'h7fff; end
                2: begin fmt = 3'd5; yaw = 16'h0000; end
                default: begin fmt = 3'($urandom_range(0, 7)); yaw = 16'($urandom); end
            endcase
            set_config(fmt, yaw);
            for (int n = 0; n < 124; n++) begin
                if (ph == 3 && n == 10) holds_asked++;
                if (ph == 5 && n == 60) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
                typed_due.push_back(1'b0);
                send_request(16'($urandom), rand_elev(), rand_dist(),
                             (ph == 3 && n < 80) ? 0 : gap_len());
            end
            i_valid <= 1'b0;
            @(posedge i_clk);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        codes = 0;
        foreach (fmt_used[c]) if (fmt_used[c]) codes++;
        $display("%0d requests, %0d results checked, %0d of 8 format codes exercised",
                 requests_taken, results_seen, codes);
        $display("stalls, one long result hold-off and one full drain were exercised");
        if (mismatches == 0 && gains_due.size() == 0) begin
            $display("tb_surround_pan_gain_calculator passed");
        end else begin
            $display("tb_surround_pan_gain_calculator failed");
        end
        $finish;
    end

endmodule
